@@ src/wpp_pkg.sv @@
// Package for the windowed peak-to-peak power meter.
// Holds the widths, register indexes, shared structs and the output clamp.
// No dependencies.
`default_nettype none

package wpp_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int TIME_BITS   = 32;
   localparam int WIN_BITS    = 16;
   localparam int GAIN_BITS   = 16;
   localparam int THR_BITS    = 12;
   localparam int OUT_BITS    = 12;
   localparam int OUT_MAX     = (1 << OUT_BITS) - 1;
   localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_MS = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN      = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_SWING = CSR_IDX_BITS'(2);

   localparam logic [WIN_BITS-1:0]  WINDOW_MS_RST = WIN_BITS'(200);
   localparam logic [GAIN_BITS-1:0] GAIN_RST      = GAIN_BITS'(41085);
   localparam logic [THR_BITS-1:0]  MIN_SWING_RST = THR_BITS'(36);

   typedef struct packed {
      logic [WIN_BITS-1:0]  window_ms;
      logic [GAIN_BITS-1:0] power_gain_q16;
      logic [THR_BITS-1:0]  min_swing_counts;
   } cfg_type;

   // one queue word: peaks as they stand after the item
   typedef struct packed {
      logic                   done;
      logic [SAMPLE_BITS-1:0] peak_high;
      logic [SAMPLE_BITS-1:0] peak_low;
   } entry_type;

   function automatic logic [OUT_BITS-1:0] sat_out(input logic [SAMPLE_BITS-1:0] v);
      logic [OUT_BITS-1:0] r;
      if (32'(v) > 32'(OUT_MAX)) begin
         r = OUT_BITS'(OUT_MAX);
      end else begin
         r = OUT_BITS'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/wpp_front.sv @@
// Front end: accepts samples, tracks the window and running peaks.
// Pushes one word per item into the queue. Uses wpp_pkg.
`default_nettype none

module wpp_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wpp_pkg::cfg_type                 cfg,
   input  wire                              item_valid,
   output logic                             item_ready,
   input  wire  [wpp_pkg::SAMPLE_BITS-1:0]  sample,
   input  wire  [wpp_pkg::TIME_BITS-1:0]    time_ms,
   output logic                             push_valid,
   input  wire                              push_ready,
   output wpp_pkg::entry_type               push_word
);
   import wpp_pkg::*;

   logic                   open_ff, open_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [SAMPLE_BITS-1:0] high_ff, high_in;
   logic [SAMPLE_BITS-1:0] low_ff, low_in;
   logic [TIME_BITS-1:0]   elapsed;
   logic                   accept;
   logic                   closing;

   assign item_ready = push_ready;
   assign push_valid = item_valid;
   assign accept     = item_valid & push_ready;
   assign elapsed    = time_ms - start_ff;
   assign closing    = open_ff & (elapsed >= TIME_BITS'(cfg.window_ms));

   always_comb begin
      open_in  = open_ff;
      start_in = start_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      if (!open_ff) begin
         // opening item: no sample taken
         open_in  = 1'b1;
         start_in = time_ms;
         high_in  = '0;
         low_in   = '1;
      end else begin
         if (sample > high_ff) high_in = sample;
         if (sample < low_ff)  low_in  = sample;
         if (closing) open_in = 1'b0;
      end
      push_word.done      = closing;
      push_word.peak_high = high_in;
      push_word.peak_low  = low_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         start_ff <= '0;
         high_ff  <= '0;
         low_ff   <= '1;
      end else if (accept) begin
         open_ff  <= open_in;
         start_ff <= start_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
      end
   end

endmodule

`default_nettype wire

@@ src/wpp_queue.sv @@
// Two-word queue between the front and back ends.
// Registered storage with a fill count. Uses wpp_pkg.
`default_nettype none

module wpp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  wpp_pkg::entry_type  push_word,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output wpp_pkg::entry_type  pop_word
);
   import wpp_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_word   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/wpp_back.sv @@
// Back end: swing, gain multiply, threshold, and the result register.
// Uses wpp_pkg.
`default_nettype none

module wpp_back (
   input  wire                            clock,
   input  wire                            reset,
   input  wpp_pkg::cfg_type               cfg,
   input  wire                            pop_valid,
   output logic                           pop_ready,
   input  wpp_pkg::entry_type             pop_word,
   output logic                           out_valid,
   input  wire                            out_ready,
   output logic                           out_done,
   output logic [wpp_pkg::OUT_BITS-1:0]   out_swing,
   output logic [wpp_pkg::OUT_BITS-1:0]   out_power
);
   import wpp_pkg::*;

   logic                   valid_ff;
   logic                   done_ff, done_in;
   logic [OUT_BITS-1:0]    swing_ff, swing_in;
   logic [OUT_BITS-1:0]    power_ff, power_in;
   logic [SAMPLE_BITS-1:0] sw;
   logic [PROD_BITS-1:0]   prod;
   logic [SAMPLE_BITS-1:0] pw;

   assign pop_ready = ~valid_ff | out_ready;

   always_comb begin
      sw = (pop_word.peak_high >= pop_word.peak_low) ?
           (pop_word.peak_high - pop_word.peak_low) : '0;
      prod = PROD_BITS'(sw) * PROD_BITS'(cfg.power_gain_q16);
      pw   = prod[PROD_BITS-1:GAIN_BITS];
      if (32'(sw) < 32'(cfg.min_swing_counts)) pw = '0;
      done_in  = pop_word.done;
      swing_in = '0;
      power_in = '0;
      if (pop_word.done) begin
         swing_in = sat_out(sw);
         power_in = sat_out(pw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready & pop_valid) begin
         done_ff  <= done_in;
         swing_ff <= swing_in;
         power_ff <= power_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_done  = done_ff;
   assign out_swing = swing_ff;
   assign out_power = power_ff;

endmodule

`default_nettype wire

@@ src/windowed_peak_to_peak_power_meter.sv @@
// Top level of the windowed peak-to-peak power meter: control registers,
// front end, queue and back end. Uses wpp_pkg, wpp_front, wpp_queue, wpp_back.
//
//  channel | ports                           | direction | content
//  --------+---------------------------------+-----------+--------------------------
//  req     | req_tvalid/tready/tdata         | in        | one sample + timestamp
//  rsp     | rsp_tvalid/tready/tdata/tuser   | out       | one result word per item
//  csr     | csr_valid/ready/index/data      | in        | control register write
//
// One word per cycle sustained while rsp is not stalled; a word taken on req goes
// through the queue storage and the result register fed by the 12x16 multiplier.
// The two-word queue lets the front keep taking words while rsp stalls, until full.
// Synchronous active-high reset; csr is always ready.
`default_nettype none

module windowed_peak_to_peak_power_meter (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [11:0] sample, [43:12] time_ms, upper bits zero
   input  wire  [wpp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [11:0] swing, [23:12] power_watts
   output logic [wpp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // [0] done_res
   output logic                                rsp_tuser,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [wpp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire  [wpp_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import wpp_pkg::*;

   cfg_type             cfg_ff;
   entry_type           push_word, pop_word;
   logic                push_valid, push_ready;
   logic                pop_valid, pop_ready;
   logic [OUT_BITS-1:0] out_swing, out_power;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms        <= WINDOW_MS_RST;
         cfg_ff.power_gain_q16   <= GAIN_RST;
         cfg_ff.min_swing_counts <= MIN_SWING_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_MS: cfg_ff.window_ms        <= WIN_BITS'(csr_data);
            CSR_GAIN:      cfg_ff.power_gain_q16   <= GAIN_BITS'(csr_data);
            CSR_MIN_SWING: cfg_ff.min_swing_counts <= csr_data[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   wpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .time_ms    (req_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   wpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   wpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_word  (pop_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_done  (rsp_tuser),
      .out_swing (out_swing),
      .out_power (out_power)
   );

   assign rsp_tdata = RSP_DATA_BITS'({out_power, out_swing});

endmodule

`default_nettype wire
